/* rtl/core/mas_pkg.sv */
// Package for the metronome accent sequencer core.
// Holds the configuration and command types, register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package mas_pkg;

    localparam int COUNT_W = 18;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Width of tempo_bpm * beat_length (8 bits by 5 bits).
    localparam int PROD_W = 13;

    localparam int MOD_MAX      = 16;
    localparam int MEAS_MOD_MAX = 32;

    localparam logic [2:0] REG_TEMPO    = 3'd0;
    localparam logic [2:0] REG_BEATS    = 3'd1;
    localparam logic [2:0] REG_NOTE     = 3'd2;
    localparam logic [2:0] REG_BEAT_LEN = 3'd3;
    localparam logic [2:0] REG_SUB_LEN  = 3'd4;
    localparam logic [2:0] REG_ACCENTS  = 3'd5;
    localparam logic [2:0] REG_RUNNING  = 3'd6;

    localparam logic [7:0] RST_TEMPO    = 8'd120;
    localparam logic [5:0] RST_BEATS    = 6'd4;
    localparam logic [4:0] RST_NOTE     = 5'd4;
    localparam logic [4:0] RST_BEAT_LEN = 5'd4;
    localparam logic [4:0] RST_SUB_LEN  = 5'd4;
    localparam logic [2:0] RST_ACCENTS  = 3'd0;
    localparam logic       RST_RUNNING  = 1'b1;

    typedef struct packed {
        logic [7:0] tempo_bpm;
        logic [5:0] beats_per_measure;
        logic [4:0] note_value;
        logic [4:0] beat_length;
        logic [4:0] sub_length;
        logic [2:0] accent_enables;
        logic       running;
    } t_cfg;

    typedef struct packed {
        logic load;    // start a period computation
        logic step;    // one restoring division step
        logic finish;  // round, saturate and store the period
        logic run;     // sequencer may take transactions
    } t_dp_cmd;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_FIN,
        ST_RUN
    } t_state;

    // Remainder of a by m for small values, m at least one; six restoring steps.
    function automatic logic [5:0] small_mod(input logic [5:0] a, input logic [5:0] m);
        logic [5:0] r;
        r = '0;
        for (int i = 5; i >= 0; i--) begin
            r = {r[4:0], a[i]};
            if (r >= m) begin
                r = r - m;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/metronome_accent_sequencer_core.sv */
// Each result is registered on acceptance; one transaction per cycle unless input stalls.
// The result register holds while the output is stalled, and input stalls meanwhile.
// After reset and after every register write the step period is recomputed by a
// bit-serial divider: input stalls through its load, divide and finish states.
// Reset is synchronous and active low; it restores the register defaults and clears all counters.
// Depends on mas_pkg, mas_ctrl and mas_datapath.
`timescale 1ns / 1ps

module metronome_accent_sequencer_core #(
    parameter int TICKS_PER_MINUTE = 250000,
    parameter int FINEST_NOTE      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_fired,
    output logic        o_pulse_led,
    output logic        o_beat_led,
    output logic        o_measure_led,
    output logic        o_sub_led
);

    localparam int DIV_BITS = $clog2(TICKS_PER_MINUTE + 1);

    mas_pkg::t_cfg    r_cfg;
    mas_pkg::t_dp_cmd w_cmd;
    logic [2:0]       w_index;
    logic             w_wr;
    logic             w_cfg_wr;
    logic [3:0]       w_leds;

    assign pready   = 1'b1;
    assign w_index  = paddr[4:2];
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_cfg_wr = w_wr && (w_index <= mas_pkg::REG_RUNNING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tempo_bpm         <= mas_pkg::RST_TEMPO;
            r_cfg.beats_per_measure <= mas_pkg::RST_BEATS;
            r_cfg.note_value        <= mas_pkg::RST_NOTE;
            r_cfg.beat_length       <= mas_pkg::RST_BEAT_LEN;
            r_cfg.sub_length        <= mas_pkg::RST_SUB_LEN;
            r_cfg.accent_enables    <= mas_pkg::RST_ACCENTS;
            r_cfg.running           <= mas_pkg::RST_RUNNING;
        end else if (w_wr) begin
            unique case (w_index)
                mas_pkg::REG_TEMPO:    r_cfg.tempo_bpm         <= pwdata[7:0];
                mas_pkg::REG_BEATS:    r_cfg.beats_per_measure <= pwdata[5:0];
                mas_pkg::REG_NOTE:     r_cfg.note_value        <= pwdata[4:0];
                mas_pkg::REG_BEAT_LEN: r_cfg.beat_length       <= pwdata[4:0];
                mas_pkg::REG_SUB_LEN:  r_cfg.sub_length        <= pwdata[4:0];
                mas_pkg::REG_ACCENTS:  r_cfg.accent_enables    <= pwdata[2:0];
                mas_pkg::REG_RUNNING:  r_cfg.running           <= pwdata[0];
                default:               r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            mas_pkg::REG_TEMPO:    prdata = 32'(r_cfg.tempo_bpm);
            mas_pkg::REG_BEATS:    prdata = 32'(r_cfg.beats_per_measure);
            mas_pkg::REG_NOTE:     prdata = 32'(r_cfg.note_value);
            mas_pkg::REG_BEAT_LEN: prdata = 32'(r_cfg.beat_length);
            mas_pkg::REG_SUB_LEN:  prdata = 32'(r_cfg.sub_length);
            mas_pkg::REG_ACCENTS:  prdata = 32'(r_cfg.accent_enables);
            mas_pkg::REG_RUNNING:  prdata = 32'(r_cfg.running);
            default:               prdata = '0;
        endcase
    end

    mas_ctrl #(
        .DIV_BITS (DIV_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (w_cfg_wr),
        .o_cmd    (w_cmd)
    );

    mas_datapath #(
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE),
        .FINEST_NOTE      (FINEST_NOTE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_tick      (i_tick),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fired     (o_fired),
        .o_leds      (w_leds)
    );

    assign o_pulse_led   = w_leds[0];
    assign o_beat_led    = w_leds[1];
    assign o_measure_led = w_leds[2];
    assign o_sub_led     = w_leds[3];

`ifndef SYNTHESIS
    // A register write must hold off input until the new period is ready.
    a_wr_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> o_in_stall)
        else $error("input not stalled after a register write");

    // No transaction is taken while a result still waits at the output.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(o_out_valid && i_out_stall))
        else $error("input open while output result is blocked");

    // A status-only transaction never reports a step.
    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_tick) |=> !o_fired)
        else $error("step reported for a status transaction");
`endif

endmodule

/* rtl/core/mas_ctrl.sv */
// Controller state machine for the metronome accent sequencer.
// Sequences the period division after reset and configuration writes; uses mas_pkg.
`timescale 1ns / 1ps

module mas_ctrl #(
    parameter int DIV_BITS = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    output mas_pkg::t_dp_cmd  o_cmd
);

    localparam int CNT_W = (DIV_BITS > 1) ? $clog2(DIV_BITS) : 1;

    mas_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_bit_cnt, n_bit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mas_pkg::ST_LOAD;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    // A configuration write restarts the computation from whatever state.
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr) begin
            n_state = mas_pkg::ST_LOAD;
        end else begin
            unique case (r_state)
                mas_pkg::ST_LOAD: n_state = mas_pkg::ST_DIV;
                mas_pkg::ST_DIV: begin
                    if (r_bit_cnt == '0) begin
                        n_state = mas_pkg::ST_FIN;
                    end
                end
                mas_pkg::ST_FIN: n_state = mas_pkg::ST_RUN;
                mas_pkg::ST_RUN: n_state = mas_pkg::ST_RUN;
                default:         n_state = mas_pkg::ST_LOAD;
            endcase
        end
    end

    always_comb begin
        n_bit_cnt = r_bit_cnt;
        if (r_state == mas_pkg::ST_LOAD) begin
            n_bit_cnt = CNT_W'(DIV_BITS - 1);
        end else if (r_state == mas_pkg::ST_DIV && r_bit_cnt != '0) begin
            n_bit_cnt = r_bit_cnt - 1'b1;
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            mas_pkg::ST_LOAD: o_cmd.load   = 1'b1;
            mas_pkg::ST_DIV:  o_cmd.step   = 1'b1;
            mas_pkg::ST_FIN:  o_cmd.finish = 1'b1;
            mas_pkg::ST_RUN:  o_cmd.run    = 1'b1;
            default:          o_cmd        = '0;
        endcase
    end

endmodule

/* rtl/core/mas_datapath.sv */
// Datapath for the metronome accent sequencer: period divider, tick counter,
// modulo counters, LED levels and the output register. Uses mas_pkg.
`timescale 1ns / 1ps

module mas_datapath #(
    parameter int TICKS_PER_MINUTE = 250000,
    parameter int FINEST_NOTE      = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mas_pkg::t_dp_cmd i_cmd,
    input  mas_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_tick,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_fired,
    output logic [3:0]       o_leds
);

    localparam int DIV_BITS = $clog2(TICKS_PER_MINUTE + 1);
    localparam int QW = (DIV_BITS >= mas_pkg::COUNT_W) ? DIV_BITS + 1 : mas_pkg::COUNT_W + 1;
    localparam int PW = mas_pkg::PROD_W;

    // ---------------- Period divider ----------------
    logic [PW-1:0]       r_div;
    logic [PW-1:0]       r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic [mas_pkg::COUNT_W-1:0] r_period;

    logic [PW:0]   w_trial;
    logic          w_take;
    logic          w_round;
    logic [QW-1:0] w_q_rnd;

    assign w_trial = {r_rem, r_quo[DIV_BITS-1]};
    assign w_take  = (w_trial >= {1'b0, r_div});
    // Odd rounding rule: up by one when the remainder reaches half the tempo.
    assign w_round = (r_rem >= PW'(i_cfg.tempo_bpm[7:1]));
    assign w_q_rnd = QW'(r_quo) + QW'(w_round);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= PW'(i_cfg.tempo_bpm) * PW'(i_cfg.beat_length);
            r_rem <= '0;
            r_quo <= DIV_BITS'(TICKS_PER_MINUTE);
        end else if (i_cmd.step) begin
            r_rem <= w_take ? PW'(w_trial - {1'b0, r_div}) : w_trial[PW-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], w_take};
        end
        if (i_cmd.finish) begin
            if (r_div == '0 || w_q_rnd > QW'(mas_pkg::COUNT_MAX)) begin
                r_period <= mas_pkg::COUNT_MAX;
            end else begin
                r_period <= w_q_rnd[mas_pkg::COUNT_W-1:0];
            end
        end
    end

    // ---------------- Moduli ----------------
    logic [4:0] w_pmod_tab [32];

    for (genvar g = 0; g < 32; g++) begin : g_pmod
        localparam int PM_RAW = (g == 0) ? 0 : FINEST_NOTE / g;
        localparam int PM = (PM_RAW < 1) ? 1 :
                            ((PM_RAW > mas_pkg::MOD_MAX) ? mas_pkg::MOD_MAX : PM_RAW);
        assign w_pmod_tab[g] = 5'(PM);
    end

    logic [5:0] w_pmod, w_bmod, w_smod, w_mmod;

    assign w_pmod = {1'b0, w_pmod_tab[i_cfg.note_value]};
    assign w_bmod = (i_cfg.beat_length == '0) ? 6'd1 :
                    ((i_cfg.beat_length > 5'(mas_pkg::MOD_MAX)) ?
                     6'(mas_pkg::MOD_MAX) : {1'b0, i_cfg.beat_length});
    assign w_smod = (i_cfg.sub_length == '0) ? 6'd1 :
                    ((i_cfg.sub_length > 5'(mas_pkg::MOD_MAX)) ?
                     6'(mas_pkg::MOD_MAX) : {1'b0, i_cfg.sub_length});
    assign w_mmod = (i_cfg.beats_per_measure == '0) ? 6'd1 :
                    ((i_cfg.beats_per_measure > 6'(mas_pkg::MEAS_MOD_MAX)) ?
                     6'(mas_pkg::MEAS_MOD_MAX) : i_cfg.beats_per_measure);

    // ---------------- Sequencer ----------------
    logic [mas_pkg::COUNT_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [3:0] r_pulse_cnt, n_pulse_cnt;
    logic [3:0] r_beat_cnt, n_beat_cnt;
    logic [3:0] r_sub_cnt, n_sub_cnt;
    logic [4:0] r_meas_cnt, n_meas_cnt;
    logic [3:0] r_leds, n_leds;
    logic       r_out_valid, n_out_valid;
    logic       r_fired, n_fired;

    logic       w_accept;
    logic [mas_pkg::COUNT_W-1:0] w_tick_inc;
    logic       w_fire;
    logic [5:0] w_np, w_nb, w_ns, w_nm;

    assign o_in_stall = !i_cmd.run || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_tick_inc = (r_tick_cnt < mas_pkg::COUNT_MAX) ? r_tick_cnt + 1'b1 : r_tick_cnt;
    assign w_fire     = i_cfg.running && (w_tick_inc >= r_period);

    assign w_np = mas_pkg::small_mod(6'(r_pulse_cnt) + 6'd1, w_pmod);
    assign w_nb = mas_pkg::small_mod(6'(r_beat_cnt) + 6'd1, w_bmod);
    assign w_ns = mas_pkg::small_mod(6'(r_sub_cnt) + 6'd1, w_smod);
    assign w_nm = mas_pkg::small_mod(6'(r_meas_cnt) + 6'd1, w_mmod);

    always_comb begin
        n_tick_cnt  = r_tick_cnt;
        n_pulse_cnt = r_pulse_cnt;
        n_beat_cnt  = r_beat_cnt;
        n_sub_cnt   = r_sub_cnt;
        n_meas_cnt  = r_meas_cnt;
        n_leds      = r_leds;
        n_fired     = r_fired;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_fired     = 1'b0;
            if (i_tick) begin
                n_tick_cnt = w_tick_inc;
                if (w_fire) begin
                    n_fired     = 1'b1;
                    n_tick_cnt  = '0;
                    n_pulse_cnt = w_np[3:0];
                    n_beat_cnt  = w_nb[3:0];
                    n_sub_cnt   = w_ns[3:0];
                    if (w_np == '0) begin
                        n_leds[0]  = ~r_leds[0];
                        n_meas_cnt = w_nm[4:0];
                        if (w_nm == '0 && i_cfg.accent_enables[1]) begin
                            n_leds[2] = ~r_leds[2];
                        end
                    end
                    if (w_nb == '0 && i_cfg.accent_enables[0]) begin
                        n_leds[1] = ~r_leds[1];
                    end
                    if (w_ns == '0 && i_cfg.accent_enables[2]) begin
                        n_leds[3] = ~r_leds[3];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_pulse_cnt <= '0;
            r_beat_cnt  <= '0;
            r_sub_cnt   <= '0;
            r_meas_cnt  <= '0;
            r_leds      <= '0;
            r_out_valid <= 1'b0;
            r_fired     <= 1'b0;
        end else begin
            r_tick_cnt  <= n_tick_cnt;
            r_pulse_cnt <= n_pulse_cnt;
            r_beat_cnt  <= n_beat_cnt;
            r_sub_cnt   <= n_sub_cnt;
            r_meas_cnt  <= n_meas_cnt;
            r_leds      <= n_leds;
            r_out_valid <= n_out_valid;
            r_fired     <= n_fired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fired     = r_fired;
    assign o_leds      = r_leds;

endmodule
